>>> design/lnec_pkg.sv
// Shared types, widths and helper functions for the leaky NLMS echo canceller.
package lnec_pkg;

	// Filter and history geometry.
	localparam int TAPS       = 512;
	localparam int TAP_W      = $clog2(TAPS);
	localparam int CNT_W      = TAP_W + 1;
	localparam int HIST_DEPTH = 8192;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	// Sample and weight formats.
	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 32;
	localparam int SFRAC    = SAMPLE_W - 1;
	localparam int WFRAC    = WEIGHT_W - 2;

	// Configuration register widths.
	localparam int DELAY_W = 13;
	localparam int MU_W    = 16;
	localparam int LEAK_W  = 16;
	localparam int FLOOR_W = 24;

	// Derived datapath widths.
	localparam int ACC_W      = WEIGHT_W + SAMPLE_W + TAP_W;
	localparam int PRED_W     = ACC_W - WFRAC;
	localparam int ERR_W      = PRED_W + 1;
	localparam int SQ_W       = 2 * SAMPLE_W;
	localparam int ENERGY_W   = SQ_W + TAP_W + 1;
	localparam int STEP_SHIFT = SFRAC + WFRAC - 16;
	localparam int MAG_W      = MU_W + SAMPLE_W;
	localparam int NUM_W      = MAG_W + STEP_SHIFT;
	localparam int QCNT_W     = $clog2(NUM_W + 1);
	localparam int STEP_W     = 48;
	localparam int LEAK_PW    = WEIGHT_W + LEAK_W + 1;
	localparam int INC_PW     = STEP_W + SAMPLE_W;
	localparam int UPD_W      = INC_PW - SFRAC + 1;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_DELAY = 2'd0;
	localparam logic [1:0] REG_MU    = 2'd1;
	localparam logic [1:0] REG_LEAK  = 2'd2;
	localparam logic [1:0] REG_FLOOR = 2'd3;

	// Register reset values.
	localparam logic [DELAY_W-1:0] DELAY_RST = '0;
	localparam logic [MU_W-1:0]    MU_RST    = MU_W'(1311);
	localparam logic [LEAK_W-1:0]  LEAK_RST  = LEAK_W'(65503);
	localparam logic [FLOOR_W-1:0] FLOOR_RST = FLOOR_W'(1073742);

	// One input beat.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] speaker_sample;
		logic signed [SAMPLE_W-1:0] mic_sample;
		logic                       buffer_end;
	} in_beat_t;

	// One result beat.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] error_sample;
		logic                       adapted;
		logic                       buffer_end_out;
	} out_beat_t;

	// Saturate a wide error value to the sample range.
	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ERR_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (&v[ERR_W-1:SAMPLE_W-1] || ~|v[ERR_W-1:SAMPLE_W-1]) begin
			r = v[SAMPLE_W-1:0];
		end else if (v[ERR_W-1]) begin
			r = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Saturate a wide weight update to the weight range.
	function automatic logic signed [WEIGHT_W-1:0] sat_weight(input logic signed [UPD_W-1:0] v);
		logic signed [WEIGHT_W-1:0] r;
		if (&v[UPD_W-1:WEIGHT_W-1] || ~|v[UPD_W-1:WEIGHT_W-1]) begin
			r = v[WEIGHT_W-1:0];
		end else if (v[UPD_W-1]) begin
			r = {1'b1, {(WEIGHT_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(WEIGHT_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

>>> design/leaky_nlms_echo_canceller.sv
// Leaky NLMS echo canceller: history and weight memories, FIR and update passes, divider.
// A new input beat is taken only in the idle state, so each sample's FIR pass, optional
// divide and update pass, and hand-over to a free result register finish before the next;
// each 512-tap pass reads one tap per cycle through the single read port of each memory,
// and the divide retires one bit a cycle.
// After reset the block clears both memories and holds in_stall high meanwhile.
// Registers return to their reset values and write position to zero on arst_n low.
module leaky_nlms_echo_canceller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lnec_pkg::in_beat_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output lnec_pkg::out_beat_t           out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lnec_pkg::PADDR_W-1:0]  paddr,
	input  logic [lnec_pkg::PDATA_W-1:0]  pwdata,
	output logic [lnec_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import lnec_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_WRITE, ST_FIR, ST_ERR, ST_PREP, ST_DIV, ST_STEP, ST_ADAPT, ST_DONE
	} state_t;

	// Memories.
	logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
	logic signed [WEIGHT_W-1:0] w_mem [TAPS];

	// Control state.
	state_t               state_q;
	logic [HIST_AW-1:0]   clr_q;
	logic [HIST_AW-1:0]   wp_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 rd_vld_s1;
	logic                 prod_vld_s2;
	logic [QCNT_W-1:0]    div_cnt_q;
	logic                 out_valid_q;
	out_beat_t            out_q;
	logic [DELAY_W-1:0]   delay_q;
	logic [MU_W-1:0]      mu_q;
	logic [LEAK_W-1:0]    leak_q;
	logic [FLOOR_W-1:0]   floor_q;

	// Datapath registers.
	in_beat_t                   in_q;
	logic                       allow_q;
	logic [HIST_AW-1:0]         tap_addr_q;
	logic [TAP_W-1:0]           widx_s1;
	logic [TAP_W-1:0]           widx_s2;
	logic signed [SAMPLE_W-1:0] hist_rd_s1;
	logic signed [WEIGHT_W-1:0] w_rd_s1;
	logic signed [WEIGHT_W+SAMPLE_W-1:0] wx_s2;
	logic [SQ_W-1:0]            xx_s2;
	logic signed [LEAK_PW-1:0]  leak_s2;
	logic signed [INC_PW-1:0]   inc_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic [ENERGY_W-1:0]        energy_q;
	logic signed [SAMPLE_W-1:0] err_q;
	logic [ENERGY_W-1:0]        div_den_q;
	logic [ENERGY_W-1:0]        div_rem_q;
	logic [NUM_W-1:0]           div_num_q;
	logic                       err_neg_q;
	logic signed [STEP_W-1:0]   step_q;

	// Combinational helpers.
	logic                       accept;
	logic                       cfg_wr;
	logic                       issue;
	logic                       pass_done;
	logic [SQ_W-1:0]            spk_sq;
	logic [SQ_W-1:0]            mic_sq;
	logic signed [PRED_W-1:0]   pred;
	logic signed [ERR_W-1:0]    err_full;
	logic [ENERGY_W-1:0]        den_sum;
	logic [SAMPLE_W-1:0]        abs_err;
	logic [MAG_W-1:0]           mag;
	logic [ENERGY_W:0]          rem_sh;
	logic                       q_bit;
	logic [STEP_W-2:0]          q_lim;
	logic signed [LEAK_PW-1:0]  leak_rnd;
	logic signed [INC_PW-1:0]   inc_rnd;
	logic signed [UPD_W-1:0]    upd_sum;
	logic                       hist_we;
	logic [HIST_AW-1:0]         hist_waddr;
	logic signed [SAMPLE_W-1:0] hist_wdata;
	logic                       w_we;
	logic [TAP_W-1:0]           w_waddr;
	logic signed [WEIGHT_W-1:0] w_wdata;

	// Handshakes.
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			REG_DELAY: prdata = PDATA_W'(delay_q);
			REG_MU:    prdata = PDATA_W'(mu_q);
			REG_LEAK:  prdata = PDATA_W'(leak_q);
			REG_FLOOR: prdata = PDATA_W'(floor_q);
		endcase
	end

	// Tap pass sequencing shared by the FIR and update passes.
	assign issue     = (state_q == ST_FIR || state_q == ST_ADAPT) && (cnt_q != CNT_W'(TAPS));
	assign pass_done = (cnt_q == CNT_W'(TAPS)) && !rd_vld_s1 && !prod_vld_s2;

	// Double-talk gate inputs.
	assign spk_sq = $signed(in_q.speaker_sample) * $signed(in_q.speaker_sample);
	assign mic_sq = $signed(in_q.mic_sample) * $signed(in_q.mic_sample);

	// Prediction rounding and error.
	always_comb begin
		pred     = PRED_W'((acc_q + $signed(ACC_W'(1) << (WFRAC - 1))) >>> WFRAC);
		err_full = ERR_W'($signed(in_q.mic_sample)) - ERR_W'(pred);
		den_sum  = energy_q + ENERGY_W'(floor_q);
		abs_err  = err_q[SAMPLE_W-1] ? SAMPLE_W'(-err_q) : SAMPLE_W'(err_q);
		mag      = MAG_W'(mu_q) * MAG_W'(abs_err);
	end

	// One restoring division step.
	always_comb begin
		rem_sh = {div_rem_q, div_num_q[NUM_W-1]};
		q_bit  = (rem_sh >= {1'b0, div_den_q});
		q_lim  = (|div_num_q[NUM_W-1:STEP_W-1]) ? {(STEP_W-1){1'b1}} : div_num_q[STEP_W-2:0];
	end

	// Weight update: leak and step increment, both rounded to nearest by adding half before the shift.
	always_comb begin
		leak_rnd = leak_s2 + $signed(LEAK_PW'(1) << 15);
		inc_rnd  = inc_s2 + $signed(INC_PW'(1) << (SFRAC - 1));
		upd_sum  = UPD_W'(leak_rnd >>> 16) + UPD_W'(inc_rnd >>> SFRAC);
		w_wdata  = (state_q == ST_CLEAR) ? '0 : sat_weight(upd_sum);
	end

	// Memory write ports.
	assign hist_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign hist_waddr = (state_q == ST_CLEAR) ? clr_q : wp_q;
	assign hist_wdata = (state_q == ST_CLEAR) ? '0 : in_q.speaker_sample;
	assign w_we       = (state_q == ST_CLEAR) || (state_q == ST_ADAPT && prod_vld_s2);
	assign w_waddr    = (state_q == ST_CLEAR) ? clr_q[TAP_W-1:0] : widx_s2;

	// Reference history memory.
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_rd_s1 <= hist_mem[tap_addr_q];
	end

	// Tap weight memory.
	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[w_waddr] <= w_wdata;
		end
		w_rd_s1 <= w_mem[cnt_q[TAP_W-1:0]];
	end

	// Sequencer, configuration registers and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			wp_q        <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			prod_vld_s2 <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			delay_q     <= DELAY_RST;
			mu_q        <= MU_RST;
			leak_q      <= LEAK_RST;
			floor_q     <= FLOOR_RST;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_DELAY: delay_q <= pwdata[DELAY_W-1:0];
					REG_MU:    mu_q    <= pwdata[MU_W-1:0];
					REG_LEAK:  leak_q  <= pwdata[LEAK_W-1:0];
					REG_FLOOR: floor_q <= pwdata[FLOOR_W-1:0];
				endcase
			end
			// The done state reloads the result register itself when it is free.
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1   <= issue;
			prod_vld_s2 <= rd_vld_s1;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					cnt_q   <= '0;
					state_q <= ST_FIR;
				end
				ST_FIR: begin
					if (pass_done) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					state_q <= allow_q ? ST_PREP : ST_DONE;
				end
				ST_PREP: begin
					div_cnt_q <= QCNT_W'(NUM_W);
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == QCNT_W'(1)) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					cnt_q   <= '0;
					state_q <= ST_ADAPT;
				end
				ST_ADAPT: begin
					if (pass_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q          <= 1'b1;
						out_q.error_sample   <= err_q;
						out_q.adapted        <= allow_q;
						out_q.buffer_end_out <= in_q.buffer_end;
						wp_q                 <= wp_q + 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_data;
		end
		widx_s2 <= widx_s1;
		if (issue) begin
			tap_addr_q <= tap_addr_q - 1'b1;
			widx_s1    <= cnt_q[TAP_W-1:0];
		end

		// Products of the current tap.
		wx_s2   <= w_rd_s1 * hist_rd_s1;
		xx_s2   <= hist_rd_s1 * hist_rd_s1;
		leak_s2 <= w_rd_s1 * $signed({1'b0, leak_q});
		inc_s2  <= step_q * hist_rd_s1;

		case (state_q)
			ST_WRITE: begin
				allow_q    <= (spk_sq != '0) && ({2'b00, mic_sq} < {spk_sq, 2'b00});
				acc_q      <= '0;
				energy_q   <= '0;
				tap_addr_q <= wp_q - HIST_AW'(delay_q);
			end
			ST_FIR: begin
				if (prod_vld_s2) begin
					acc_q    <= acc_q + ACC_W'(wx_s2);
					energy_q <= energy_q + ENERGY_W'(xx_s2);
				end
			end
			ST_ERR: begin
				err_q     <= sat_sample(err_full);
				div_den_q <= (den_sum == '0) ? ENERGY_W'(1) : den_sum;
			end
			ST_PREP: begin
				div_num_q <= NUM_W'(mag) << STEP_SHIFT;
				div_rem_q <= '0;
				err_neg_q <= err_q[SAMPLE_W-1];
			end
			ST_DIV: begin
				div_rem_q <= q_bit ? ENERGY_W'(rem_sh - {1'b0, div_den_q}) : ENERGY_W'(rem_sh);
				div_num_q <= {div_num_q[NUM_W-2:0], q_bit};
			end
			ST_STEP: begin
				step_q     <= err_neg_q ? -$signed({1'b0, q_lim}) : $signed({1'b0, q_lim});
				tap_addr_q <= wp_q - HIST_AW'(delay_q);
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// A result only appears out of the final state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	// Weights are written only by the clearing sweep or the update pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		w_we |-> (state_q == ST_CLEAR || state_q == ST_ADAPT))
		else $error("weight write outside clear or update");

	// The divider has run out before the step is formed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (div_cnt_q == '0))
		else $error("step formed before division finished");

	// A tap fetch never takes the tap counter past the filter length.
	assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> (cnt_q <= CNT_W'(TAPS)))
		else $error("tap counter ran past the filter length");
`endif

endmodule
